// File: hdl/prwl_pkg.sv
// shared types and constants for the priority reader-writer lock manager
package prwl_pkg;

  localparam int MaxTasksDef = 32;
  localparam int PrioLevelsDef = 64;
  localparam int IdW = 5;
  localparam int PrioW = 6;
  localparam int KindW = 3;
  localparam int StatusW = 3;

  localparam logic [KindW-1:0] K_READ = 3'd0;
  localparam logic [KindW-1:0] K_TRY_READ = 3'd1;
  localparam logic [KindW-1:0] K_WRITE = 3'd2;
  localparam logic [KindW-1:0] K_TRY_WRITE = 3'd3;
  localparam logic [KindW-1:0] K_UNLOCK = 3'd4;

  localparam logic [StatusW-1:0] ST_OK = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID = 3'd1;
  localparam logic [StatusW-1:0] ST_BUSY = 3'd2;
  localparam logic [StatusW-1:0] ST_DEADLOCK = 3'd3;
  localparam logic [StatusW-1:0] ST_EPERM = 3'd4;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [IdW-1:0] id;
  } entry_t;

  // queue command from the controller to the cell row
  typedef struct packed {
    logic ins;
    logic pop;
    entry_t ent;
  } qcmd_t;

endpackage

// File: hdl/prwl_cell.sv
// one slot of a sorted wait queue
module prwl_cell (
  input  logic clk,
  input  logic rst,
  input  prwl_pkg::qcmd_t cmd,
  input  logic prev_valid,
  input  logic prev_goes_after,
  input  prwl_pkg::entry_t prev_ent,
  input  logic next_valid,
  input  prwl_pkg::entry_t next_ent,
  output logic valid,
  output logic goes_after,
  output prwl_pkg::entry_t ent
);
  import prwl_pkg::*;

  // new entry sorts after this one if our priority is equal or better
  assign goes_after = valid && (ent.prio <= cmd.ent.prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= next_valid;
      ent <= next_ent;
    end else if (cmd.ins) begin
      if (!goes_after) begin
        if (prev_goes_after) begin
          valid <= 1'b1;
          ent <= cmd.ent;
        end else begin
          valid <= prev_valid;
          ent <= prev_ent;
        end
      end
    end
  end
endmodule

// File: hdl/prwl_queue.sv
// sorted wait queue built as a row of cells
module prwl_queue #(
  parameter int Depth = prwl_pkg::MaxTasksDef
) (
  input  logic clk,
  input  logic rst,
  input  prwl_pkg::qcmd_t cmd,
  output logic head_valid,
  output prwl_pkg::entry_t head,
  output logic full
);
  import prwl_pkg::*;

  logic [Depth-1:0] v;
  logic [Depth-1:0] ga;
  entry_t e [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic pv, pga, nv;
    entry_t pe, ne;
    if (i == 0) begin : g_first
      assign pv = 1'b0;
      assign pga = 1'b1;
      assign pe = cmd.ent;
    end else begin : g_mid
      assign pv = v[i-1];
      assign pga = ga[i-1];
      assign pe = e[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign nv = 1'b0;
      assign ne = e[i];
    end else begin : g_nxt
      assign nv = v[i+1];
      assign ne = e[i+1];
    end
    prwl_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .prev_valid(pv), .prev_goes_after(pga), .prev_ent(pe),
      .next_valid(nv), .next_ent(ne),
      .valid(v[i]), .goes_after(ga[i]), .ent(e[i])
    );
  end

  assign head_valid = v[0];
  assign head = e[0];
  assign full = v[Depth-1];

`ifndef SYNTH
  a_contig: assert property (@(posedge clk) disable iff (rst)
    (v[Depth-1:1] & ~v[Depth-2:0]) == '0) else $error("queue holes");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && !v[1] |=> !v[0]) else $error("pop failed");
  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins && !cmd.pop && !v[Depth-1] |=> v[0]) else $error("insert lost");
`endif
endmodule

// File: hdl/priority_rwlock_manager.sv
// top level of the priority reader-writer lock manager
// Usage: pulse start with a request while busy is low; every result comes
// back as a one-cycle strobe with last marking the final beat of a request.
// A request is decided in the cycle after acceptance; its first beat is
// registered to go out in the cycle after; busy is high until S_IDLE again.
// An unlock that wakes a reader run gives one beat per woken reader, one per
// cycle, each dequeue shifting the cell row of the read queue by one place.
// A new request is taken only when the previous one is done and busy is low.
// The two wait queues are rows of cells sorted by priority; insert and pop
// each update every cell of the row at once.
// Reset clears the lock to free and empties both queues.
// The receiver cannot stall: beats are never held back.
module priority_rwlock_manager #(
  parameter int MAX_TASKS = prwl_pkg::MaxTasksDef,
  parameter int PRIORITY_LEVELS = prwl_pkg::PrioLevelsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [prwl_pkg::KindW-1:0] kind,
  input  logic [prwl_pkg::IdW-1:0] task_id,
  input  logic [prwl_pkg::PrioW-1:0] task_priority,
  input  logic wait_allowed,
  input  logic in_interrupt,
  input  logic scheduler_locked,
  output logic strobe,
  output logic [prwl_pkg::StatusW-1:0] status,
  output logic pended,
  output logic woken_valid,
  output logic [prwl_pkg::IdW-1:0] woken_task,
  output logic woken_as_writer,
  output logic last
);
  import prwl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAKE = 2'd2;
  localparam logic [1:0] S_GAP = 2'd3;
  localparam logic [PrioW-1:0] PrioMax = PrioW'(PRIORITY_LEVELS - 1);

  logic [1:0] state, state_next;
  logic [KindW-1:0] r_kind;
  logic [IdW-1:0] r_id;
  logic [PrioW-1:0] r_prio;
  logic r_wait, r_intr, r_slock;
  logic signed [31:0] hold_count, hold_count_next;
  logic [IdW-1:0] owner_task, owner_task_next;
  logic owner_valid, owner_valid_next;
  logic limited, limited_next;
  logic [PrioW-1:0] limit, limit_next;

  qcmd_t rcmd, wcmd;
  logic rhv, whv, rfull, wfull;
  entry_t rhead, whead;

  prwl_queue #(.Depth(MAX_TASKS)) u_rq (
    .clk(clk), .rst(rst), .cmd(rcmd),
    .head_valid(rhv), .head(rhead), .full(rfull));
  prwl_queue #(.Depth(MAX_TASKS)) u_wq (
    .clk(clk), .rst(rst), .cmd(wcmd),
    .head_valid(whv), .head(whead), .full(wfull));

  assign busy = (state != S_IDLE);

  logic o_stb, o_pend, o_wv, o_ww, o_last;
  logic [StatusW-1:0] o_st;
  logic [IdW-1:0] o_wt;
  logic is_owner, ahead, next_run;

  always_comb begin
    state_next = state;
    hold_count_next = hold_count;
    owner_task_next = owner_task;
    owner_valid_next = owner_valid;
    limited_next = limited;
    limit_next = limit;
    rcmd = '0;
    wcmd = '0;
    rcmd.ent = '{prio: r_prio, id: r_id};
    wcmd.ent = '{prio: r_prio, id: r_id};
    o_stb = 1'b0;
    o_st = ST_OK;
    o_pend = 1'b0;
    o_wv = 1'b0;
    o_wt = '0;
    o_ww = 1'b0;
    o_last = 1'b1;
    is_owner = owner_valid && (owner_task == r_id);
    ahead = !whv || (r_prio < whead.prio);
    next_run = rhv && !(limited && rhead.prio >= limit);
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        o_stb = 1'b1;
        state_next = S_GAP;
        if (r_kind > K_UNLOCK) begin
          o_st = ST_INVALID;
        end else if (r_kind != K_UNLOCK && r_intr) begin
          o_st = ST_INVALID;
        end else if (r_kind != K_UNLOCK && r_slock) begin
          o_st = ST_DEADLOCK;
        end else if (r_kind == K_READ || r_kind == K_TRY_READ) begin
          if (r_kind == K_TRY_READ && is_owner) o_st = ST_INVALID;
          else if (r_kind == K_TRY_READ && (hold_count < 0 || !ahead)) o_st = ST_BUSY;
          else if (hold_count >= 0 && ahead) begin
            if (hold_count == S32_MAX) o_st = ST_INVALID;
            else hold_count_next = hold_count + 32'sd1;
          end else if (is_owner) o_st = ST_INVALID;
          else if (!r_wait) o_st = ST_INVALID;
          else if (rfull) o_st = ST_BUSY;
          else begin
            rcmd.ins = 1'b1;
            o_pend = 1'b1;
          end
        end else if (r_kind == K_WRITE || r_kind == K_TRY_WRITE) begin
          if (r_kind == K_TRY_WRITE && (hold_count > 0 || (hold_count < 0 && !is_owner)))
            o_st = ST_BUSY;
          else if (hold_count == 0) begin
            hold_count_next = -32'sd1;
            owner_task_next = r_id;
            owner_valid_next = 1'b1;
          end else if (hold_count < 0 && is_owner) begin
            if (hold_count == S32_MIN) o_st = ST_INVALID;
          end else if (!r_wait) o_st = ST_INVALID;
          else if (wfull) o_st = ST_BUSY;
          else begin
            wcmd.ins = 1'b1;
            o_pend = 1'b1;
          end
        end else begin
          if (hold_count == 0 || (hold_count < 0 && !is_owner)) o_st = ST_EPERM;
          else if (hold_count > 1) hold_count_next = hold_count - 32'sd1;
          else if (hold_count < -1) hold_count_next = hold_count + 32'sd1;
          else begin
            hold_count_next = '0;
            owner_task_next = '0;
            owner_valid_next = 1'b0;
            if (whv && (!rhv || whead.prio <= rhead.prio)) begin
              wcmd.pop = 1'b1;
              hold_count_next = -32'sd1;
              owner_task_next = whead.id;
              owner_valid_next = 1'b1;
              o_wv = 1'b1;
              o_wt = whead.id;
              o_ww = 1'b1;
            end else if (rhv) begin
              rcmd.pop = 1'b1;
              hold_count_next = 32'sd1;
              limited_next = whv;
              limit_next = whead.prio;
              o_wv = 1'b1;
              o_wt = rhead.id;
              o_last = 1'b0;
              state_next = S_WAKE;
            end
          end
        end
      end
      S_WAKE: begin
        // previous beat is already out; decide whether it was last
        o_stb = 1'b1;
        if (next_run) begin
          rcmd.pop = 1'b1;
          hold_count_next = hold_count + 32'sd1;
          o_wv = 1'b1;
          o_wt = rhead.id;
          o_last = 1'b0;
        end else begin
          o_stb = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // peek lets the final reader beat carry last: each beat is computed in the cycle before it goes out
  logic pend_beat;
  logic [IdW-1:0] pend_id;
  logic [StatusW-1:0] pend_st;
  logic pend_p, pend_wv, pend_ww, pend_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hold_count <= '0;
      owner_task <= '0;
      owner_valid <= 1'b0;
      limited <= 1'b0;
      limit <= '0;
      pend_beat <= 1'b0;
    end else begin
      state <= (state == S_GAP) ? S_IDLE : state_next;
      hold_count <= hold_count_next;
      owner_task <= owner_task_next;
      owner_valid <= owner_valid_next;
      limited <= limited_next;
      limit <= limit_next;
      pend_beat <= o_stb;
    end
    if (start && state == S_IDLE) begin
      r_kind <= kind;
      r_id <= task_id;
      r_prio <= (task_priority > PrioMax) ? PrioMax : task_priority;
      r_wait <= wait_allowed;
      r_intr <= in_interrupt;
      r_slock <= scheduler_locked;
    end
    pend_id <= o_wt;
    pend_st <= o_st;
    pend_p <= o_pend;
    pend_wv <= o_wv;
    pend_ww <= o_ww;
    pend_last <= o_last;
  end

  // a held beat goes out once the following cycle knows whether more follow
  assign strobe = pend_beat;
  assign status = pend_st;
  assign pended = pend_p;
  assign woken_valid = pend_wv;
  assign woken_task = pend_id;
  assign woken_as_writer = pend_ww;
  assign last = pend_last || (pend_wv && !pend_ww && !o_stb);

`ifndef SYNTH
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && !$past(o_stb) |-> !strobe || last) else $error("stray beat");
  a_writer_owner: assert property (@(posedge clk) disable iff (rst)
    hold_count < 0 |-> owner_valid) else $error("writer without owner");
  a_reader_noowner: assert property (@(posedge clk) disable iff (rst)
    hold_count >= 0 |-> !owner_valid) else $error("reader with owner");
`endif
endmodule
